/* rtl/eqmon_pkg.sv */
// Shared types and constants of the equilibration monitor.
package eqmon_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TOL_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SET      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd5;

    // Control from the sequencer to the sample window
    typedef struct packed {
        logic read;
        logic push;
    } window_ctrl_t;

endpackage

/* rtl/equilibration_monitor_unit.sv */
// Top level of the equilibration monitor: sequencer, registers and result stage.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+-------------------
//  in      | step_number, sample_temperature           | in        | in_valid/in_stall
//  out     | command, set_point                        | out       | out_valid/out_stall
//  cfg     | cfg_index, cfg_data                       | in        | cfg_write
//
// A request passes the ring read at acceptance, then the window update, the target scaling
// multiply and the tolerance multiply, before its decision is loaded into the output
// register. The input stalls until that load, so the next request is taken in the
// cycle after it; no new request is taken while one is in flight. The decision
// waits only when the output register still holds an untaken result. Reset is
// asynchronous and active low; no clearing pass is run, since only written ring
// entries are read.
module equilibration_monitor_unit #(
    parameter int WINDOW = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [eqmon_pkg::TIME_W-1:0]      step_number,
    input  logic [eqmon_pkg::SAMPLE_W-1:0]    sample_temperature,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [eqmon_pkg::CMD_W-1:0]       command,
    output logic [eqmon_pkg::SAMPLE_W-1:0]    set_point,
    input  logic                              cfg_write,
    input  logic [eqmon_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eqmon_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eqmon_pkg::*;

    localparam int CntW  = $clog2(WINDOW + 1);
    localparam int SumW  = SAMPLE_W + CntW;
    localparam int ProdW = SumW + TOL_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PUSH   = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_PROD   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers
    logic [SAMPLE_W-1:0] target_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic [TIME_W-1:0]   interval_reg;
    logic [TIME_W-1:0]   steady_time_reg;
    logic [TIME_W-1:0]   timeout_reg;
    logic [TIME_W-1:0]   start_reg;

    // Phase timing state
    logic [TIME_W-1:0]   last_assess_reg;
    logic [TIME_W-1:0]   last_adjust_reg;

    // Latched request
    logic [TIME_W-1:0]   step_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Datapath pipeline
    logic [SumW-1:0]     scaled_reg;
    logic [SumW-1:0]     diff_reg;
    logic [ProdW-1:0]    rhs_reg;
    logic                due_reg;
    logic                steady_reg;
    logic                abort_reg;

    // Result stage
    logic                out_valid_reg;
    logic [CMD_W-1:0]    command_reg;
    logic [SAMPLE_W-1:0] set_point_reg;

    logic                accept;
    logic                load;
    logic                off_target;
    logic                adjust;
    logic [CMD_W-1:0]    cmd_next;
    logic [SumW-1:0]     win_sum;
    logic [CntW-1:0]     win_count;
    window_ctrl_t        win_ctrl;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    // free the output register before loading a fresh result
    assign load     = (state_reg == ST_DECIDE) && (!out_valid_reg || !out_stall);

    // Read the oldest ring entry as the request arrives; push in the cycle after
    assign win_ctrl.read = accept;
    assign win_ctrl.push = (state_reg == ST_PUSH);

    eqmon_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .sample (sample_reg),
        .sum    (win_sum),
        .count  (win_count)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_PROD;
            ST_PROD:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Relative error test without division: |sum - target*n| * 2^16 >= tol * target*n
    assign off_target = ({diff_reg, FRAC_W'(0)} >= rhs_reg);
    assign adjust     = due_reg && off_target;

    // Priority: phase complete (only when no adjustment is made), abort, set temperature, none
    always_comb
    begin
        if (steady_reg && !adjust)
        begin
            cmd_next = CMD_COMPLETE;
        end
        else if (abort_reg)
        begin
            cmd_next = CMD_ABORT;
        end
        else if (adjust)
        begin
            cmd_next = CMD_SET;
        end
        else
        begin
            cmd_next = CMD_NONE;
        end
    end

    // Control state, configuration and phase timing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            target_reg      <= '0;
            tol_reg         <= TOL_W'(655);
            interval_reg    <= TIME_W'(100);
            steady_time_reg <= TIME_W'(1000);
            timeout_reg     <= TIME_W'(100000);
            start_reg       <= '0;
            last_assess_reg <= '0;
            last_adjust_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TARGET:   target_reg      <= cfg_data[SAMPLE_W-1:0];
                    REG_TOL:      tol_reg         <= cfg_data[TOL_W-1:0];
                    REG_INTERVAL: interval_reg    <= cfg_data[TIME_W-1:0];
                    REG_STEADY:   steady_time_reg <= cfg_data[TIME_W-1:0];
                    REG_TIMEOUT:  timeout_reg     <= cfg_data[TIME_W-1:0];
                    REG_START:
                    begin
                        // a new phase begins: restart both timers
                        start_reg       <= cfg_data[TIME_W-1:0];
                        last_assess_reg <= cfg_data[TIME_W-1:0];
                        last_adjust_reg <= cfg_data[TIME_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (load)
            begin
                if (due_reg)
                begin
                    last_assess_reg <= step_reg;
                end
                if (cmd_next == CMD_SET)
                begin
                    last_adjust_reg <= step_reg;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg   <= step_number;
            sample_reg <= sample_temperature;
        end

        if (state_reg == ST_SCALE)
        begin
            scaled_reg <= SumW'(target_reg) * SumW'(win_count);
            // time differences wrap modulo 2^32
            due_reg    <= ((step_reg - last_assess_reg) >= interval_reg);
            steady_reg <= ((step_reg - last_adjust_reg) >= steady_time_reg);
            abort_reg  <= ((step_reg - start_reg) >= timeout_reg);
        end

        if (state_reg == ST_PROD)
        begin
            rhs_reg  <= ProdW'(tol_reg) * ProdW'(scaled_reg);
            diff_reg <= (win_sum >= scaled_reg) ? (win_sum - scaled_reg)
                                                : (scaled_reg - win_sum);
        end

        if (load)
        begin
            command_reg   <= cmd_next;
            set_point_reg <= (cmd_next == CMD_SET) ? target_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign set_point = set_point_reg;

endmodule

/* rtl/eqmon_window.sv */
// Sample ring memory with running window sum and fill count.
module eqmon_window #(
    parameter int WINDOW = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  eqmon_pkg::window_ctrl_t         ctrl,
    input  logic [eqmon_pkg::SAMPLE_W-1:0]  sample,
    output logic [eqmon_pkg::SAMPLE_W+$clog2(WINDOW+1)-1:0] sum,
    output logic [$clog2(WINDOW+1)-1:0]     count
);
    import eqmon_pkg::*;

    localparam int CntW = $clog2(WINDOW + 1);
    localparam int SumW = SAMPLE_W + CntW;
    localparam int PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [PosW-1:0]     pos_reg, pos_next;
    logic [SumW-1:0]     sum_reg, sum_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                full;

    assign full = (count_reg == CntW'(WINDOW));

    // Ring port: read the oldest entry, write the new sample at the same place
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            ring_mem[pos_reg] <= sample;
        end
        if (ctrl.read)
        begin
            rd_data_reg <= ring_mem[pos_reg];
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        if (ctrl.push)
        begin
            // drop the oldest sample only once the window is full
            if (full)
            begin
                sum_next = sum_reg - SumW'(rd_data_reg) + SumW'(sample);
            end
            else
            begin
                sum_next   = sum_reg + SumW'(sample);
                count_next = count_reg + CntW'(1);
            end
            pos_next = (pos_reg == PosW'(WINDOW - 1)) ? '0 : pos_reg + PosW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

/* rtl/eqmon_checker.sv */
// Port-level assertions for the equilibration monitor, bound to its top level.
module eqmon_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [eqmon_pkg::CMD_W-1:0]     command,
    input logic [eqmon_pkg::SAMPLE_W-1:0]  set_point
);
    import eqmon_pkg::*;

    // Hold off further requests while one is being worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("request accepted while previous one in flight");

    // No result can appear the cycle after a request is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Set point is only carried with a set temperature command
    a_set_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (command != CMD_SET)) |-> (set_point == '0))
        else $error("set point non-zero without set command");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");

endmodule

bind equilibration_monitor_unit eqmon_checker u_eqmon_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command),
    .set_point (set_point)
);

/* tb/sv/testbench.sv */
// Self-checking testbench of the equilibration monitor: directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import eqmon_pkg::*;

    localparam int WINDOW          = 64;
    localparam int PIPE_LATENCY    = 4;     // sets the drain wait at the end of the run
    localparam int RANDOM_REQUESTS = 850;
    localparam int WATCHDOG_NS     = 5_000_000;

    // One request: the time step and the temperature sampled at it
    typedef struct packed {
        logic [TIME_W-1:0]   step;
        logic [SAMPLE_W-1:0] temp;
    } sample_req_t;

    // One result: the command and its set point
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SAMPLE_W-1:0] set_point;
    } command_t;

    logic                  clk                = 1'b0;
    logic                  rst_n              = 1'b0;
    logic                  in_valid           = 1'b0;
    logic                  in_stall;
    logic [TIME_W-1:0]     step_number        = '0;
    logic [SAMPLE_W-1:0]   sample_temperature = '0;
    logic                  out_valid;
    logic                  out_stall          = 1'b0;
    logic [CMD_W-1:0]      command;
    logic [SAMPLE_W-1:0]   set_point;
    logic                  cfg_write          = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index          = '0;
    logic [CFG_DATA_W-1:0] cfg_data           = '0;

    sample_req_t pending_samples[$];      // requests not yet offered to the block
    command_t    expected_commands[$];    // predicted results, oldest first

    logic        in_taken      = 1'b0;    // the request on the input was accepted last edge
    int unsigned tx_idle_pct   = 35;
    int unsigned rx_idle_pct   = 80;
    int unsigned error_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned writes_done   = 0;
    int unsigned cmd_tally [4] = '{default: 0};

    // Mirror of the register file
    logic [SAMPLE_W-1:0] tgt_temp     = '0;
    logic [TOL_W-1:0]    tol_frac     = 16'd655;
    logic [TIME_W-1:0]   assess_every = 32'd100;
    logic [TIME_W-1:0]   steady_span  = 32'd1000;
    logic [TIME_W-1:0]   abort_after  = 32'd100000;
    logic [TIME_W-1:0]   phase_start  = '0;

    // Mirror of the sample window and the phase timestamps
    logic [SAMPLE_W-1:0] ring_mirror [WINDOW];
    int unsigned         ring_slot    = 0;
    logic [29:0]         window_total = '0;
    int unsigned         samples_held = 0;
    logic [TIME_W-1:0]   assessed_at  = '0;
    logic [TIME_W-1:0]   adjusted_at  = '0;

    // 8 ns period: high half, then low half
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    equilibration_monitor_unit #(
        .WINDOW(WINDOW)
    ) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .step_number        (step_number),
        .sample_temperature (sample_temperature),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .command            (command),
        .set_point          (set_point),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Advance the window mirror by one sample and work out the command it yields.
    task automatic predict_command(input logic [TIME_W-1:0] now,
                                   input logic [SAMPLE_W-1:0] temp);
        logic [63:0]       total_wide;
        logic [63:0]       scaled;
        logic [63:0]       gap;
        logic [63:0]       lhs;
        logic [63:0]       rhs;
        logic [TIME_W-1:0] since_assess;
        logic [TIME_W-1:0] since_adjust;
        logic [TIME_W-1:0] since_start;
        logic              adjust;
        command_t          res;

        // Drop the oldest sample only once the window is full
        if (samples_held >= WINDOW)
            window_total = window_total - ring_mirror[ring_slot];
        else
            samples_held++;
        ring_mirror[ring_slot] = temp;
        window_total = window_total + temp;
        ring_slot = (ring_slot + 1 == WINDOW) ? 0 : ring_slot + 1;

        // Assess the mean by cross-multiplication; all time gaps wrap at 32 bits
        adjust = 1'b0;
        since_assess = now - assessed_at;
        if (since_assess >= assess_every)
        begin
            assessed_at = now;
            total_wide  = window_total;
            scaled      = tgt_temp * samples_held;
            gap         = (total_wide >= scaled) ? total_wide - scaled : scaled - total_wide;
            lhs         = gap << FRAC_W;
            rhs         = tol_frac * scaled;
            adjust      = (lhs >= rhs);
        end

        // Priority: completion (unless adjusting), then abort, then a new set point
        since_adjust  = now - adjusted_at;
        since_start   = now - phase_start;
        res.set_point = '0;
        if (since_adjust >= steady_span && !adjust)
            res.cmd = CMD_COMPLETE;
        else if (since_start >= abort_after)
            res.cmd = CMD_ABORT;
        else if (adjust)
        begin
            adjusted_at   = now;
            res.cmd       = CMD_SET;
            res.set_point = tgt_temp;
        end
        else
            res.cmd = CMD_NONE;
        expected_commands.insert(expected_commands.size(), res);
    endtask

    // Write one register at an idle moment and mirror it; a new start time opens a phase.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_TARGET:   tgt_temp     = value[SAMPLE_W-1:0];
            REG_TOL:      tol_frac     = value[TOL_W-1:0];
            REG_INTERVAL: assess_every = value;
            REG_STEADY:   steady_span  = value;
            REG_TIMEOUT:  abort_after  = value;
            REG_START:
            begin
                phase_start = value;
                assessed_at = value;
                adjusted_at = value;
            end
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_request(input logic [TIME_W-1:0] step,
                                 input logic [SAMPLE_W-1:0] temp);
        sample_req_t req;
        req.step = step;
        req.temp = temp;
        pending_samples.insert(pending_samples.size(), req);
    endtask

    // Hold until every request has gone in and every result has come back
    task automatic wait_for_idle();
        while (pending_samples.size() != 0 || in_valid || expected_commands.size() != 0)
            @(posedge clk);
    endtask

    // A temperature within about target/2^shift of the target, clamped to the 24-bit range
    function automatic logic [SAMPLE_W-1:0] temp_near_target(input int unsigned shift);
        int unsigned span;
        int unsigned mag;
        int unsigned t;
        span = (tgt_temp >> shift) + 1;
        mag  = $urandom_range(0, span);
        if ($urandom_range(1) != 0)
            t = (tgt_temp + mag > 32'h00FF_FFFF) ? 32'h00FF_FFFF : tgt_temp + mag;
        else
            t = (mag > tgt_temp) ? 0 : tgt_temp - mag;
        return t[SAMPLE_W-1:0];
    endfunction

    // Driver: offer the next request at the falling edge once the previous one is taken,
    // and drive the output stall at random.
    always @(negedge clk)
    begin
        sample_req_t req;
        out_stall <= ($urandom_range(99) < rx_idle_pct);
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                req = pending_samples.pop_front();
                in_valid           <= 1'b1;
                step_number        <= req.step;
                sample_temperature <= req.temp;
                requests_sent++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: predict on every accepted request, compare every accepted result.
    always @(posedge clk)
    begin
        command_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_command(step_number, sample_temperature);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_commands.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got command %0d set point %06h",
                         $time, command, set_point);
            end
            else
            begin
                want = expected_commands.pop_front();
                cmd_tally[want.cmd]++;
                if (command !== want.cmd)
                begin
                    error_count++;
                    $display("%0t: command mismatch, expected %0d, got %0d",
                             $time, want.cmd, command);
                end
                if (set_point !== want.set_point)
                begin
                    error_count++;
                    $display("%0t: set point mismatch, expected %06h, got %06h",
                             $time, want.set_point, set_point);
                end
            end
        end
    end

    // Stimulus: directed requests, then random phases of fresh register settings.
    initial
    begin
        int unsigned        random_queued;
        int unsigned        burst;
        int unsigned        shift;
        bit                 noisy;
        logic [TIME_W-1:0]  next_step;
        logic [TIME_W-1:0]  start_val;

        random_queued = 0;
        next_step     = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero target, so each assessment asks for an adjustment;
        // the last step lies far past the timeout.
        queue_request(32'd0, 24'd0);
        queue_request(32'd1, 24'hFF_FFFF);
        queue_request(32'd100, 24'h12_3456);
        queue_request(32'd1100, 24'h00_ABCD);
        queue_request(32'hFFFF_FFFF, 24'hFF_FFFF);
        wait_for_idle();

        // Widest target and tolerance, assessment on every step, no steady wait,
        // largest timeout; a step behind the start wraps to a huge difference.
        write_setting(REG_TARGET, 32'h00FF_FFFF);
        write_setting(REG_TOL, 32'h0000_FFFF);
        write_setting(REG_INTERVAL, 32'd0);
        write_setting(REG_STEADY, 32'd0);
        write_setting(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_setting(REG_START, 32'h5555_5555);
        queue_request(32'h5555_5555, 24'hFF_FFFF);
        queue_request(32'h5555_5555, 24'hFF_FFFF);
        queue_request(32'h5555_5556, 24'd0);
        queue_request(32'hAAAA_AAAA, 24'hFF_FFFF);
        queue_request(32'h5555_5554, 24'h80_0000);
        wait_for_idle();

        // Zero tolerance: every assessment is off target
        write_setting(REG_TOL, 32'd0);
        queue_request(32'h5555_5557, 24'hFF_FFFF);
        queue_request(32'h5555_5558, 24'hFF_FFFF);
        wait_for_idle();

        // A short phase across the 32-bit wrap of the step counter, reaching the timeout
        write_setting(REG_TARGET, 32'h0019_0000);
        write_setting(REG_TOL, 32'h0000_1000);
        write_setting(REG_INTERVAL, 32'd2);
        write_setting(REG_STEADY, 32'd6);
        write_setting(REG_TIMEOUT, 32'd24);
        write_setting(REG_START, 32'hFFFF_FFF0);
        for (int i = 0; i < 10; i++)
            queue_request(32'hFFFF_FFF0 + 3 * i, temp_near_target(8));
        wait_for_idle();
        next_step = 32'hFFFF_FFF0 + 27;

        // Random phases: mostly runs of rising steps with temperatures near the target,
        // with some stray requests and whole phases of noise.
        while (random_queued < RANDOM_REQUESTS)
        begin
            // Sender idles lightly first, then the receiver, then neither
            if (random_queued < RANDOM_REQUESTS / 3)
            begin
                tx_idle_pct = 35;
                rx_idle_pct = 80;
            end
            else if (random_queued < 2 * RANDOM_REQUESTS / 3)
            begin
                tx_idle_pct = 80;
                rx_idle_pct = 35;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if ($urandom_range(3) != 0)
                case ($urandom_range(9))
                    0:       write_setting(REG_TARGET, 32'd0);
                    1:       write_setting(REG_TARGET, 32'h00FF_FFFF);
                    default: write_setting(REG_TARGET, $urandom_range(24'h10_0000, 24'hF0_0000));
                endcase
            if ($urandom_range(3) != 0)
                case ($urandom_range(9))
                    0:       write_setting(REG_TOL, 32'd0);
                    1:       write_setting(REG_TOL, 32'h0000_FFFF);
                    2:       write_setting(REG_TOL, $urandom_range(0, 16'hFFFF));
                    default: write_setting(REG_TOL, $urandom_range(100, 16'h3000));
                endcase
            if ($urandom_range(3) != 0)
                case ($urandom_range(9))
                    0:       write_setting(REG_INTERVAL, 32'd1);
                    1:       write_setting(REG_INTERVAL, 32'hFFFF_FFFF);
                    2:       write_setting(REG_INTERVAL, $urandom);
                    default: write_setting(REG_INTERVAL, $urandom_range(1, 12));
                endcase
            if ($urandom_range(3) != 0)
                case ($urandom_range(9))
                    0:       write_setting(REG_STEADY, 32'd0);
                    1:       write_setting(REG_STEADY, 32'hFFFF_FFFF);
                    2:       write_setting(REG_STEADY, $urandom);
                    default: write_setting(REG_STEADY, $urandom_range(1, 60));
                endcase
            if ($urandom_range(3) != 0)
                case ($urandom_range(9))
                    0:       write_setting(REG_TIMEOUT, 32'd0);
                    1:       write_setting(REG_TIMEOUT, 32'hFFFF_FFFF);
                    2:       write_setting(REG_TIMEOUT, $urandom);
                    default: write_setting(REG_TIMEOUT, $urandom_range(20, 600));
                endcase
            // A new start time opens a fresh phase; otherwise carry on from the last step
            if ($urandom_range(1) != 0)
            begin
                case ($urandom_range(9))
                    0:       start_val = 32'd0;
                    1:       start_val = 32'hFFFF_FFFF;
                    2:       start_val = 32'hFFFF_FFFF - $urandom_range(0, 40);
                    default: start_val = $urandom;
                endcase
                write_setting(REG_START, start_val);
                next_step = start_val + $urandom_range(0, 2);
            end

            case ($urandom_range(4))
                0:       shift = 24;
                1:       shift = 12;
                2:       shift = 8;
                3:       shift = 5;
                default: shift = 3;
            endcase
            noisy = ($urandom_range(9) == 0);
            burst = $urandom_range(15, 60);
            repeat (burst)
            begin
                if (noisy || $urandom_range(19) == 0)
                    queue_request($urandom, $urandom_range(0, 24'hFF_FFFF));
                else
                begin
                    // Mostly small steps forward, now and then a long jump to reach the timeout
                    if ($urandom_range(29) == 0)
                        next_step = next_step + $urandom_range(0, 2000);
                    else
                        next_step = next_step + $urandom_range(0, 3);
                    queue_request(next_step, temp_near_target(shift));
                end
            end
            random_queued += burst;
            wait_for_idle();
        end

        // Let any stray result show up before judging the run
        repeat (PIPE_LATENCY * 4) @(posedge clk);

        $display("Covered %0d requests and %0d register writes, wrapping steps and edge settings",
                 requests_sent, writes_done);
        $display("Commands checked: none %0d, complete %0d, abort %0d, set %0d",
                 cmd_tally[CMD_NONE], cmd_tally[CMD_COMPLETE], cmd_tally[CMD_ABORT],
                 cmd_tally[CMD_SET]);
        if (error_count == 0)
            $display("[equilibration_monitor_unit] OK");
        else
            $display("[equilibration_monitor_unit] ERROR");
        $finish;
    end

    // Watchdog: end a run that hangs
    initial
    begin
        #(WATCHDOG_NS);
        $display("[equilibration_monitor_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/eqmon_pkg.sv
rtl/eqmon_window.sv
rtl/equilibration_monitor_unit.sv
rtl/eqmon_checker.sv
tb/sv/testbench.sv
